### hdl/rfss_pkg.sv
// Package for the radio frequency scan sequencer.
// Field widths, reset values, request/status/config codes and shared types.
// No dependencies.
`default_nettype none

package rfss_pkg;

  // Default width in bits of an offset in Hz.
  localparam int unsigned OFFSET_BITS_DEF = 23;

  // Fixed field widths
  localparam int unsigned SCAN_RANGE_W = 21;
  localparam int unsigned SCAN_STEP_W  = 20;
  localparam int unsigned MISS_LIMIT_W = 4;
  localparam int unsigned MIN_ZOOM_W   = 16;
  localparam int unsigned FREQ_ERR_W   = 8;
  localparam int unsigned CFG_DATA_W   = 21;
  localparam int unsigned CFG_IDX_W    = 2;
  // max(scan_step / 4, min_zoom_step) fits in 18 bits
  localparam int unsigned ZOOM_STEP_W  = 18;

  // Register reset values
  localparam logic [SCAN_RANGE_W-1:0] SCAN_RANGE_RST = 21'd100000;
  localparam logic [SCAN_STEP_W-1:0]  SCAN_STEP_RST  = 20'd5000;
  localparam logic [MISS_LIMIT_W-1:0] MISS_LIMIT_RST = 4'd3;
  localparam logic [MIN_ZOOM_W-1:0]   MIN_ZOOM_RST   = 16'd397;

  // Miss counter saturates here
  localparam logic [MISS_LIMIT_W-1:0] MISS_MAX = 4'd15;

  typedef enum logic [1:0] {
    REQ_START  = 2'd0,
    REQ_MEAS   = 2'd1,
    REQ_CANCEL = 2'd2,
    REQ_LOAD   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_STEPPING  = 3'd0,
    ST_SAVED     = 3'd1,
    ST_KEPT      = 3'd2,
    ST_NO_SIGNAL = 3'd3,
    ST_CANCELLED = 3'd4,
    ST_RADIO_ERR = 3'd5,
    ST_IGNORED   = 3'd6
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCAN_RANGE = 2'd0,
    CFG_SCAN_STEP  = 2'd1,
    CFG_MISS_LIMIT = 2'd2,
    CFG_MIN_ZOOM   = 2'd3
  } cfg_idx_e;

  // Configuration registers as seen by the core
  typedef struct packed {
    logic [SCAN_RANGE_W-1:0] scan_range;
    logic [SCAN_STEP_W-1:0]  scan_step;
    logic [MISS_LIMIT_W-1:0] miss_limit;
    logic [MIN_ZOOM_W-1:0]   min_zoom_step;
  } cfg_t;

  // Fixed-width part of a registered input word
  typedef struct packed {
    logic [1:0]                   req_type;
    logic                         decode_hit;
    logic                         radio_ok;
    logic signed [FREQ_ERR_W-1:0] freq_error;
    logic                         load_valid;
  } item_t;

endpackage

`default_nettype wire

### hdl/rfss_in_if.sv
// Input channel of the scan sequencer: valid/ready plus request word.
// Depends on rfss_pkg.
`default_nettype none

interface rfss_in_if #(
  parameter int unsigned OFFSET_BITS = rfss_pkg::OFFSET_BITS_DEF
);
  logic                                   valid;
  logic                                   ready;
  logic [1:0]                             req_type;
  logic                                   decode_hit;
  logic                                   radio_ok;
  logic signed [rfss_pkg::FREQ_ERR_W-1:0] freq_error;
  logic signed [OFFSET_BITS-1:0]          load_offset;
  logic                                   load_valid;

  modport source (
    output valid, req_type, decode_hit, radio_ok, freq_error, load_offset, load_valid,
    input  ready
  );
  modport sink (
    input  valid, req_type, decode_hit, radio_ok, freq_error, load_offset, load_valid,
    output ready
  );
endinterface

`default_nettype wire

### hdl/rfss_out_if.sv
// Result channel of the scan sequencer: valid/ready plus tune/status word.
// Depends on rfss_pkg.
`default_nettype none

interface rfss_out_if #(
  parameter int unsigned OFFSET_BITS = rfss_pkg::OFFSET_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [OFFSET_BITS-1:0] tune_offset;
  logic                          tune_enable;
  logic                          busy_res;
  logic [2:0]                    status;
  logic signed [OFFSET_BITS-1:0] stored_offset_out;
  logic                          stored_valid_out;

  modport source (
    output valid, tune_offset, tune_enable, busy_res, status, stored_offset_out,
           stored_valid_out,
    input  ready
  );
  modport sink (
    input  valid, tune_offset, tune_enable, busy_res, status, stored_offset_out,
           stored_valid_out,
    output ready
  );
endinterface

`default_nettype wire

### hdl/rfss_cfg_regs.sv
// Configuration register file of the scan sequencer, write-only.
// Depends on rfss_pkg.
`default_nettype none

module rfss_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            we_i,
  input  wire logic [rfss_pkg::CFG_IDX_W-1:0]  idx_i,
  input  wire logic [rfss_pkg::CFG_DATA_W-1:0] data_i,
  output rfss_pkg::cfg_t                       cfg_o
);

  rfss_pkg::cfg_t cfg_q;

  // Register writes, truncated to each register's width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scan_range    <= rfss_pkg::SCAN_RANGE_RST;
      cfg_q.scan_step     <= rfss_pkg::SCAN_STEP_RST;
      cfg_q.miss_limit    <= rfss_pkg::MISS_LIMIT_RST;
      cfg_q.min_zoom_step <= rfss_pkg::MIN_ZOOM_RST;
    end else if (we_i) begin
      unique case (rfss_pkg::cfg_idx_e'(idx_i))
        rfss_pkg::CFG_SCAN_RANGE: cfg_q.scan_range <= data_i[rfss_pkg::SCAN_RANGE_W-1:0];
        rfss_pkg::CFG_SCAN_STEP:  cfg_q.scan_step  <= data_i[rfss_pkg::SCAN_STEP_W-1:0];
        rfss_pkg::CFG_MISS_LIMIT: cfg_q.miss_limit <= data_i[rfss_pkg::MISS_LIMIT_W-1:0];
        rfss_pkg::CFG_MIN_ZOOM:   cfg_q.min_zoom_step <= data_i[rfss_pkg::MIN_ZOOM_W-1:0];
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### hdl/rfss_in_stage.sv
// Input register of the scan sequencer; holds one request word for the core.
// Depends on rfss_pkg and rfss_in_if.
`default_nettype none

module rfss_in_stage #(
  parameter int unsigned OFFSET_BITS = rfss_pkg::OFFSET_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  rfss_in_if.sink                       req,
  input  wire logic                     take_i,
  output logic                          valid_o,
  output rfss_pkg::item_t               item_o,
  output logic signed [OFFSET_BITS-1:0] load_offset_o
);

  logic                          valid_q;
  rfss_pkg::item_t               item_q;
  logic signed [OFFSET_BITS-1:0] load_offset_q;

  // Slot is free when empty or being consumed this cycle
  assign req.ready = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req.ready) begin
      valid_q <= req.valid;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (req.ready && req.valid) begin
      item_q.req_type   <= req.req_type;
      item_q.decode_hit <= req.decode_hit;
      item_q.radio_ok   <= req.radio_ok;
      item_q.freq_error <= req.freq_error;
      item_q.load_valid <= req.load_valid;
      load_offset_q     <= req.load_offset;
    end
  end

  assign valid_o       = valid_q;
  assign item_o        = item_q;
  assign load_offset_o = load_offset_q;

endmodule

`default_nettype wire

### hdl/rfss_core.sv
// Scan sequencer state and next-state logic with the result register.
// Depends on rfss_pkg and rfss_out_if.
`default_nettype none

module rfss_core #(
  parameter int unsigned OFFSET_BITS = rfss_pkg::OFFSET_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire rfss_pkg::cfg_t                  cfg_i,
  input  wire logic                            valid_i,
  input  wire rfss_pkg::item_t                 item_i,
  input  wire logic signed [OFFSET_BITS-1:0]   load_offset_i,
  output logic                                 take_o,
  rfss_out_if.source                           res
);

  // Working width: holds any offset +/- a step, and twice an offset
  localparam int unsigned CW = ((OFFSET_BITS > 22) ? OFFSET_BITS : 22) + 3;
  localparam logic signed [CW-1:0] OffMax = CW'((64'sd1 <<< (OFFSET_BITS - 1)) - 64'sd1);
  localparam logic signed [CW-1:0] OffMin = -OffMax - CW'(1);
  localparam int unsigned OB = OFFSET_BITS;
  localparam int unsigned ZW = rfss_pkg::ZOOM_STEP_W;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_WINDOW  = 5'b00010,
    PH_ZOOM    = 5'b00100,
    PH_VCAND   = 5'b01000,
    PH_VSTORED = 5'b10000
  } phase_e;

  function automatic logic signed [OFFSET_BITS-1:0] sat_off(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    r = (v > OffMax) ? OffMax : ((v < OffMin) ? OffMin : v);
    return r[OFFSET_BITS-1:0];
  endfunction

  // State
  phase_e                  phase_q, phase_d;
  logic signed [OB-1:0]    cur_q, cur_d;
  logic signed [OB-1:0]    wfirst_q, wfirst_d;
  logic signed [OB-1:0]    wlast_q, wlast_d;
  logic                    hit_seen_q, hit_seen_d;
  logic [rfss_pkg::MISS_LIMIT_W-1:0] miss_q, miss_d;
  logic signed [OB-1:0]    best_q, best_d;
  logic signed [OB-1:0]    zend_q, zend_d;
  logic [ZW-1:0]           zstep_q, zstep_d;
  logic [7:0]              cand_q, cand_d;
  logic signed [OB-1:0]    prev_q, prev_d;
  logic signed [OB-1:0]    stored_q, stored_d;
  logic                    stored_valid_q, stored_valid_d;

  // Result register
  logic                    out_valid_q;
  logic signed [OB-1:0]    tune_q, tune_d;
  logic                    en_q, en_d;
  rfss_pkg::status_e       status_q, status_d;
  logic                    busy_q;
  logic signed [OB-1:0]    sto_out_q;
  logic                    stv_out_q;

  // Widened operands
  logic signed [CW-1:0] range_w, step_w, zstep_w, cur_w;
  logic [7:0]           fe_abs;
  logic                 hit, rok;

  // Window update
  logic                                hs_n;
  logic signed [OB-1:0]                wf_n, wl_n;
  logic [rfss_pkg::MISS_LIMIT_W-1:0]   mc_n;
  logic                                end_miss, end_range;
  logic signed [OB-1:0]                win_next;
  // Zoom setup from the finished window
  logic signed [OB:0]                  wsum;
  logic signed [OB-1:0]                zs_best, zs_end, zs_start;
  logic [ZW-1:0]                       zs_step, step_q4;
  // Zoom stepping
  logic signed [OB-1:0]                zoom_next;
  logic signed [CW-1:0]                zoom_lhs, zoom_rhs;

  assign take_o = valid_i && (!out_valid_q || res.ready);

  assign range_w = CW'(cfg_i.scan_range);
  assign step_w  = CW'(cfg_i.scan_step);
  assign zstep_w = CW'(zstep_q);
  assign cur_w   = CW'(cur_q);
  assign hit     = item_i.decode_hit;
  assign rok     = item_i.radio_ok;
  assign fe_abs  = item_i.freq_error[7] ? (~item_i.freq_error + 8'd1) : item_i.freq_error;

  // Window hit/miss bookkeeping
  always_comb begin
    hs_n     = hit_seen_q;
    wf_n     = wfirst_q;
    wl_n     = wlast_q;
    mc_n     = miss_q;
    end_miss = 1'b0;
    if (hit) begin
      if (!hit_seen_q) begin
        wf_n = cur_q;
        hs_n = 1'b1;
      end
      wl_n = cur_q;
      mc_n = '0;
    end else if (hit_seen_q) begin
      mc_n     = (miss_q < rfss_pkg::MISS_MAX) ? miss_q + 1'b1 : miss_q;
      end_miss = (mc_n >= cfg_i.miss_limit);
    end
  end

  assign win_next  = sat_off(cur_w + step_w);
  assign end_range = CW'(win_next) > range_w;

  // Zoom pass setup: midpoint, quarter step bounded below, bounds widened by a step
  assign wsum     = (OB + 1)'(wf_n) + (OB + 1)'(wl_n);
  assign zs_best  = OB'(wsum >>> 1);
  assign step_q4  = ZW'(cfg_i.scan_step >> 2);
  assign zs_step  = (step_q4 < ZW'(cfg_i.min_zoom_step)) ? ZW'(cfg_i.min_zoom_step) : step_q4;
  assign zs_end   = sat_off(CW'(wl_n) + step_w);
  assign zs_start = sat_off(CW'(wf_n) - step_w);

  // Zoom step and end test at twice the scale
  assign zoom_next = sat_off(cur_w + zstep_w);
  assign zoom_lhs  = CW'(zoom_next) <<< 1;
  assign zoom_rhs  = (CW'(zend_q) <<< 1) + zstep_w;

  // Next state and result word
  always_comb begin
    phase_d        = phase_q;
    cur_d          = cur_q;
    wfirst_d       = wfirst_q;
    wlast_d        = wlast_q;
    hit_seen_d     = hit_seen_q;
    miss_d         = miss_q;
    best_d         = best_q;
    zend_d         = zend_q;
    zstep_d        = zstep_q;
    cand_d         = cand_q;
    prev_d         = prev_q;
    stored_d       = stored_q;
    stored_valid_d = stored_valid_q;
    tune_d         = '0;
    en_d           = 1'b0;
    status_d       = rfss_pkg::ST_IGNORED;

    unique case (rfss_pkg::req_e'(item_i.req_type))
      rfss_pkg::REQ_START: begin
        if (phase_q == PH_IDLE) begin
          hit_seen_d = 1'b0;
          miss_d     = '0;
          wfirst_d   = '0;
          wlast_d    = '0;
          prev_d     = stored_q;
          cur_d      = sat_off(-range_w);
          phase_d    = PH_WINDOW;
          tune_d     = cur_d;
          en_d       = 1'b1;
          status_d   = rfss_pkg::ST_STEPPING;
        end
      end

      rfss_pkg::REQ_CANCEL: begin
        if (phase_q != PH_IDLE) begin
          phase_d  = PH_IDLE;
          tune_d   = stored_q;
          en_d     = 1'b1;
          status_d = rfss_pkg::ST_CANCELLED;
        end
      end

      rfss_pkg::REQ_LOAD: begin
        if (phase_q == PH_IDLE) begin
          stored_valid_d = item_i.load_valid;
          stored_d       = item_i.load_valid ? load_offset_i : '0;
          status_d       = rfss_pkg::ST_STEPPING;
        end
      end

      rfss_pkg::REQ_MEAS: begin
        unique case (phase_q)
          PH_WINDOW: begin
            if (!rok) begin
              phase_d  = PH_IDLE;
              status_d = rfss_pkg::ST_RADIO_ERR;
            end else begin
              hit_seen_d = hs_n;
              wfirst_d   = wf_n;
              wlast_d    = wl_n;
              miss_d     = mc_n;
              if (!end_miss) begin
                cur_d = win_next;
              end
              if (end_miss || end_range) begin
                en_d = 1'b1;
                if (!hs_n) begin
                  // no hit anywhere in the window
                  phase_d  = PH_IDLE;
                  tune_d   = '0;
                  status_d = rfss_pkg::ST_NO_SIGNAL;
                end else begin
                  best_d   = zs_best;
                  zstep_d  = zs_step;
                  zend_d   = zs_end;
                  cur_d    = zs_start;
                  phase_d  = PH_ZOOM;
                  tune_d   = zs_start;
                  status_d = rfss_pkg::ST_STEPPING;
                end
              end else begin
                tune_d   = win_next;
                en_d     = 1'b1;
                status_d = rfss_pkg::ST_STEPPING;
              end
            end
          end

          PH_ZOOM: begin
            en_d     = 1'b1;
            status_d = rfss_pkg::ST_STEPPING;
            if (!rok) begin
              phase_d = PH_VCAND;
              tune_d  = best_q;
            end else if (hit) begin
              best_d  = cur_q;
              phase_d = PH_VCAND;
              tune_d  = cur_q;
            end else begin
              cur_d = zoom_next;
              if (zoom_lhs > zoom_rhs) begin
                phase_d = PH_VCAND;
                tune_d  = best_q;
              end else begin
                tune_d = zoom_next;
              end
            end
          end

          PH_VCAND: begin
            cand_d = fe_abs;
            en_d   = 1'b1;
            if (!stored_valid_q) begin
              stored_d       = best_q;
              stored_valid_d = 1'b1;
              phase_d        = PH_IDLE;
              tune_d         = best_q;
              status_d       = rfss_pkg::ST_SAVED;
            end else if (!hit) begin
              phase_d  = PH_IDLE;
              tune_d   = stored_q;
              status_d = rfss_pkg::ST_KEPT;
            end else begin
              phase_d  = PH_VSTORED;
              tune_d   = prev_q;
              status_d = rfss_pkg::ST_STEPPING;
            end
          end

          PH_VSTORED: begin
            phase_d = PH_IDLE;
            en_d    = 1'b1;
            // stored offset lost lock, or the candidate is better centered
            if (!hit || (cand_q < fe_abs)) begin
              stored_d       = best_q;
              stored_valid_d = 1'b1;
              tune_d         = best_q;
              status_d       = rfss_pkg::ST_SAVED;
            end else begin
              tune_d   = stored_q;
              status_d = rfss_pkg::ST_KEPT;
            end
          end

          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end

      default: begin
        phase_d = phase_q;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_IDLE;
      cur_q          <= '0;
      wfirst_q       <= '0;
      wlast_q        <= '0;
      hit_seen_q     <= 1'b0;
      miss_q         <= '0;
      best_q         <= '0;
      zend_q         <= '0;
      zstep_q        <= '0;
      cand_q         <= '0;
      prev_q         <= '0;
      stored_q       <= '0;
      stored_valid_q <= 1'b0;
    end else if (take_o) begin
      phase_q        <= phase_d;
      cur_q          <= cur_d;
      wfirst_q       <= wfirst_d;
      wlast_q        <= wlast_d;
      hit_seen_q     <= hit_seen_d;
      miss_q         <= miss_d;
      best_q         <= best_d;
      zend_q         <= zend_d;
      zstep_q        <= zstep_d;
      cand_q         <= cand_d;
      prev_q         <= prev_d;
      stored_q       <= stored_d;
      stored_valid_q <= stored_valid_d;
    end
  end

  // Result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take_o) begin
      out_valid_q <= 1'b1;
    end else if (res.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      tune_q    <= tune_d;
      en_q      <= en_d;
      status_q  <= status_d;
      busy_q    <= (phase_d != PH_IDLE);
      sto_out_q <= stored_d;
      stv_out_q <= stored_valid_d;
    end
  end

  assign res.valid             = out_valid_q;
  assign res.tune_offset       = tune_q;
  assign res.tune_enable       = en_q;
  assign res.busy_res          = busy_q;
  assign res.status            = status_q;
  assign res.stored_offset_out = sto_out_q;
  assign res.stored_valid_out  = stv_out_q;

endmodule

`default_nettype wire

### hdl/radio_frequency_scan_sequencer.sv
// Top level of the radio frequency scan sequencer.
// Depends on rfss_pkg, rfss_in_if, rfss_out_if, rfss_cfg_regs, rfss_in_stage, rfss_core.
//
//   port         dir  handshake       word
//   req_i        in   valid/ready     req_type, decode_hit, radio_ok, freq_error,
//                                     load_offset, load_valid
//   res_o        out  valid/ready     tune_offset, tune_enable, busy_res, status,
//                                     stored_offset_out, stored_valid_out
//   cfg_*        in   write enable    cfg_idx_i selects register, cfg_data_i value
//
// One word per cycle sustained while results are taken; each request yields exactly one
// result word. A request passes the input register, then one pass of next-state logic
// into the result register; all sequencer state updates in the same cycle.
// A stalled result holds the core; the input register still takes a word if empty.
// Reset (async, active low) clears control state and loads register defaults.
`default_nettype none

module radio_frequency_scan_sequencer #(
  parameter int unsigned OFFSET_BITS = rfss_pkg::OFFSET_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  rfss_in_if.sink                              req_i,
  rfss_out_if.source                           res_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [rfss_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [rfss_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  rfss_pkg::cfg_t                cfg;
  rfss_pkg::item_t               item;
  logic                          item_valid;
  logic                          take;
  logic signed [OFFSET_BITS-1:0] load_offset;

  rfss_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  rfss_in_stage #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req           (req_i),
    .take_i        (take),
    .valid_o       (item_valid),
    .item_o        (item),
    .load_offset_o (load_offset)
  );

  rfss_core #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .valid_i       (item_valid),
    .item_i        (item),
    .load_offset_i (load_offset),
    .take_o        (take),
    .res           (res_o)
  );

endmodule

`default_nettype wire

### hdl/rfss_checker.sv
// Port-level checks for the scan sequencer, bound to the top level.
// Depends on rfss_pkg and radio_frequency_scan_sequencer.
`default_nettype none

module rfss_checker #(
  parameter int unsigned OFFSET_BITS = rfss_pkg::OFFSET_BITS_DEF
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          res_valid,
  input wire logic                          res_ready,
  input wire logic signed [OFFSET_BITS-1:0] res_tune_offset,
  input wire logic                          res_tune_enable,
  input wire logic                          res_busy,
  input wire logic [2:0]                    res_status,
  input wire logic signed [OFFSET_BITS-1:0] res_stored_offset,
  input wire logic                          res_stored_valid
);

  // A stalled result word stays valid and holds its status and tune offset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_status) && $stable(res_tune_offset))
    else $error("stalled result word changed");

  // No tune means a zero offset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_tune_enable |-> res_tune_offset == '0)
    else $error("tune offset nonzero while tune disabled");

  // A saved calibration is stored, valid, tuned to, and ends the scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_status == rfss_pkg::ST_SAVED |->
      res_stored_valid && res_stored_offset == res_tune_offset && !res_busy)
    else $error("saved result inconsistent");

  // Radio error and cancel both end the scan; radio error never tunes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && (res_status == rfss_pkg::ST_RADIO_ERR || res_status == rfss_pkg::ST_CANCELLED)
      |-> !res_busy && (res_tune_enable == (res_status == rfss_pkg::ST_CANCELLED)))
    else $error("terminating result still busy or wrong tune");

endmodule

bind radio_frequency_scan_sequencer rfss_checker #(
  .OFFSET_BITS (OFFSET_BITS)
) u_rfss_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .res_valid         (res_o.valid),
  .res_ready         (res_o.ready),
  .res_tune_offset   (res_o.tune_offset),
  .res_tune_enable   (res_o.tune_enable),
  .res_busy          (res_o.busy_res),
  .res_status        (res_o.status),
  .res_stored_offset (res_o.stored_offset_out),
  .res_stored_valid  (res_o.stored_valid_out)
);

`default_nettype wire
